### hdl/qrg_pkg.sv
// qrg_pkg: shared types, widths and the arctangent table of the rotation gate
// no dependencies; used by every module of the block
package qrg_pkg;

  localparam int AMP_W     = 18;  // Q1.16 amplitudes
  localparam int ANGLE_W   = 16;
  localparam int CW        = 34;  // cordic x, y, z datapath width
  localparam int COEF_W    = 32;  // clamped coefficient, Q1.30
  localparam int STEPS     = 30;
  localparam int SH_W      = 5;
  localparam int COEF_FRAC = 30;
  localparam int GAIN_Q30  = 652032874;

  typedef enum logic [1:0] {
    GATE_PHASE = 2'd0,
    GATE_RX    = 2'd1,
    GATE_RY    = 2'd2,
    GATE_RZ    = 2'd3
  } gate_t;

  typedef logic signed [AMP_W-1:0] amp_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 neg;
    gate_t                func;
    amp_t                 a0r;
    amp_t                 a0i;
    amp_t                 a1r;
    amp_t                 a1i;
  } cord_t;

  function automatic logic signed [CW-1:0] atan_q(input int i);
    int t;
    case (i)
      0: t = 536870912;  1: t = 316933406;  2: t = 167458907;  3: t = 85004756;
      4: t = 42667331;   5: t = 21354465;   6: t = 10679838;   7: t = 5340245;
      8: t = 2670163;    9: t = 1335087;    10: t = 667544;    11: t = 333772;
      12: t = 166886;    13: t = 83443;     14: t = 41722;     15: t = 20861;
      16: t = 10430;     17: t = 5215;      18: t = 2608;      19: t = 1304;
      20: t = 652;       21: t = 326;       22: t = 163;       23: t = 81;
      24: t = 41;        25: t = 20;        26: t = 10;        27: t = 5;
      28: t = 3;         29: t = 1;
      default: t = 0;
    endcase
    return CW'(t);
  endfunction

endpackage

### hdl/qrg_cell.sv
// qrg_cell: one cordic rotation step with its pipeline register
// depends on qrg_pkg
module qrg_cell import qrg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic [SH_W-1:0]      shift,
  input  logic signed [CW-1:0] atan,
  input  logic                 in_valid,
  input  cord_t                in_d,
  output logic                 out_valid,
  output cord_t                out_d
);

  logic  valid_r;
  cord_t d_r, d_nxt;
  logic signed [CW-1:0] dx, dy;

  assign dx = in_d.y >>> shift;
  assign dy = in_d.x >>> shift;

  always_comb begin
    d_nxt = in_d;
    if (!in_d.z[CW-1]) begin
      d_nxt.x = in_d.x - dx;
      d_nxt.y = in_d.y + dy;
      d_nxt.z = in_d.z - atan;
    end else begin
      d_nxt.x = in_d.x + dx;
      d_nxt.y = in_d.y - dy;
      d_nxt.z = in_d.z + atan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_d     = d_r;

endmodule

### hdl/qrg_apply.sv
// qrg_apply: coefficient clamp and selection, products, rounding and saturation
// depends on qrg_pkg
module qrg_apply import qrg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  cord_t                  in_d,
  output logic                   out_valid,
  output logic [4*AMP_W-1:0]     out_data
);

  localparam int PW = COEF_W + AMP_W;
  localparam int SW = PW + 1;
  localparam logic signed [COEF_W-1:0] ONE = COEF_W'(64'sd1 <<< COEF_FRAC);

  typedef logic signed [COEF_W-1:0] coef_t;

  logic signed [CW-1:0] xn, yn;
  coef_t c, s, ns;
  coef_t ca_nxt [4], cb_nxt [4], ca_r [4], cb_r [4];
  amp_t  aa_nxt [4], ab_nxt [4], aa_r [4], ab_r [4];
  logic signed [PW-1:0] pa_r [4], pb_r [4];
  logic signed [SW-1:0] sum [4];
  logic signed [SW-COEF_FRAC-1:0] rnd [4];
  amp_t res_nxt [4], res_r [4];
  logic v1_r, v2_r, v3_r;

  function automatic coef_t clamp(input logic signed [CW-1:0] v);
    if (v > CW'(ONE))       return ONE;
    else if (v < -CW'(ONE)) return -ONE;
    else                    return v[COEF_W-1:0];
  endfunction

  assign xn = in_d.neg ? -in_d.x : in_d.x;
  assign yn = in_d.neg ? -in_d.y : in_d.y;
  assign c  = clamp(xn);
  assign s  = clamp(yn);
  assign ns = -s;

  // operand pairs per output: new = ca*aa + cb*ab
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ca_nxt[k] = c;
    end
    case (in_d.func)
      GATE_PHASE: begin
        ca_nxt[0] = ONE; aa_nxt[0] = in_d.a0r; cb_nxt[0] = '0; ab_nxt[0] = in_d.a1i;
        ca_nxt[1] = ONE; aa_nxt[1] = in_d.a0i; cb_nxt[1] = '0; ab_nxt[1] = in_d.a1r;
        aa_nxt[2] = in_d.a1r; cb_nxt[2] = ns; ab_nxt[2] = in_d.a1i;
        aa_nxt[3] = in_d.a1i; cb_nxt[3] = s;  ab_nxt[3] = in_d.a1r;
      end
      GATE_RX: begin
        aa_nxt[0] = in_d.a0r; cb_nxt[0] = s;  ab_nxt[0] = in_d.a1i;
        aa_nxt[1] = in_d.a0i; cb_nxt[1] = ns; ab_nxt[1] = in_d.a1r;
        aa_nxt[2] = in_d.a1r; cb_nxt[2] = s;  ab_nxt[2] = in_d.a0i;
        aa_nxt[3] = in_d.a1i; cb_nxt[3] = ns; ab_nxt[3] = in_d.a0r;
      end
      GATE_RY: begin
        aa_nxt[0] = in_d.a0r; cb_nxt[0] = ns; ab_nxt[0] = in_d.a1r;
        aa_nxt[1] = in_d.a0i; cb_nxt[1] = ns; ab_nxt[1] = in_d.a1i;
        aa_nxt[2] = in_d.a1r; cb_nxt[2] = s;  ab_nxt[2] = in_d.a0r;
        aa_nxt[3] = in_d.a1i; cb_nxt[3] = s;  ab_nxt[3] = in_d.a0i;
      end
      default: begin
        aa_nxt[0] = in_d.a0r; cb_nxt[0] = s;  ab_nxt[0] = in_d.a0i;
        aa_nxt[1] = in_d.a0i; cb_nxt[1] = ns; ab_nxt[1] = in_d.a0r;
        aa_nxt[2] = in_d.a1r; cb_nxt[2] = ns; ab_nxt[2] = in_d.a1i;
        aa_nxt[3] = in_d.a1i; cb_nxt[3] = s;  ab_nxt[3] = in_d.a1r;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum[k] = SW'(pa_r[k]) + SW'(pb_r[k]) + SW'(64'sd1 <<< (COEF_FRAC - 1));
      rnd[k] = sum[k][SW-1:COEF_FRAC];
      if (rnd[k] > (SW-COEF_FRAC)'(2**(AMP_W-1) - 1)) begin
        res_nxt[k] = {1'b0, {(AMP_W-1){1'b1}}};
      end else if (rnd[k] < -(SW-COEF_FRAC)'(2**(AMP_W-1))) begin
        res_nxt[k] = {1'b1, {(AMP_W-1){1'b0}}};
      end else begin
        res_nxt[k] = rnd[k][AMP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        ca_r[k]  <= ca_nxt[k];
        cb_r[k]  <= cb_nxt[k];
        aa_r[k]  <= aa_nxt[k];
        ab_r[k]  <= ab_nxt[k];
        pa_r[k]  <= ca_r[k] * aa_r[k];
        pb_r[k]  <= cb_r[k] * ab_r[k];
        res_r[k] <= res_nxt[k];
      end
    end
  end

  assign out_valid = v3_r;
  assign out_data  = {res_r[3], res_r[2], res_r[1], res_r[0]};

endmodule

### hdl/qubit_rotation_gate_apply.sv
// qubit_rotation_gate_apply: top level of the single-qubit rotation gate
// depends on qrg_pkg, qrg_cell and qrg_apply
//
// Applies a phase, X, Y or Z rotation to one qubit's amplitude pair per beat.
// The angle (full 16-bit range = 4 pi) is folded into the right half-plane
// and fed to a row of 30 cordic cells, one rotation step per cell; then one
// stage clamps and picks the matrix coefficients, one multiplies (eight
// 32x18 products), and one rounds, sums and saturates into the output
// register. One beat is taken every cycle while the pipe is not stalled.
// The whole row advances together: when the output beat is held by
// out_tready low, the input side stalls as well.
module qubit_rotation_gate_apply import qrg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // angle[15:0], amp0_re[33:16], amp0_im[51:34], amp1_re[69:52], amp1_im[87:70]
  input  logic [87:0] in_tdata,
  // func[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // new0_re[17:0], new0_im[35:18], new1_re[53:36], new1_im[71:54]
  output logic [71:0] out_tdata
);

  logic                en;
  logic [ANGLE_W-1:0]  angle;
  logic [31:0]         p, pf;
  logic                fold;
  cord_t               head;
  cord_t               link  [STEPS+1];
  logic                vlink [STEPS+1];

  // whole pipe moves whenever the output register is free or being drained
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  assign angle = in_tdata[15:0];
  // phase gate rotates by theta, the others by theta/2
  assign p     = (gate_t'(in_tuser) == GATE_PHASE) ? {angle[14:0], 17'd0}
                                                     : {angle, 16'd0};
  // quadrants two and three: rotate by pi and negate the results
  assign fold  = p[31] ^ p[30];
  assign pf    = fold ? {~p[31], p[30:0]} : p;

  always_comb begin
    head.x    = CW'(GAIN_Q30);
    head.y    = '0;
    head.z    = CW'(signed'(pf));
    head.neg  = fold;
    head.func = gate_t'(in_tuser);
    head.a0r  = in_tdata[33:16];
    head.a0i  = in_tdata[51:34];
    head.a1r  = in_tdata[69:52];
    head.a1i  = in_tdata[87:70];
  end

  assign link[0]  = head;
  assign vlink[0] = in_tvalid;

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    qrg_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .shift     (SH_W'(i)),
      .atan      (atan_q(i)),
      .in_valid  (vlink[i]),
      .in_d      (link[i]),
      .out_valid (vlink[i+1]),
      .out_d     (link[i+1])
    );
  end

  qrg_apply u_apply (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vlink[STEPS]),
    .in_d      (link[STEPS]),
    .out_valid (out_tvalid),
    .out_data  (out_tdata)
  );

endmodule
